[sv/qlbs_pkg.sv]
// Package: shared types and constants for the queued LED blink sequencer.
`default_nettype none
package qlbs_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam int ELAPSED_W   = 18;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam int GAP_SHIFT   = 2;

    localparam int  APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_LED_ENABLE = 3'd0;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_BLINK = 2'd1,
        CMD_ON    = 2'd2,
        CMD_OFF   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_BLINK,
        OP_DIRECT
    } t_op_kind;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  blink_count;
        logic [15:0] phase_ms;
        logic        force_req;
    } t_in_item;

    typedef struct packed {
        logic led_lit;
        logic accepted;
        logic busy_res;
    } t_out_item;

    typedef struct packed {
        t_op_kind    kind;
        logic        level;
        logic        force_req;
        logic [7:0]  blink_count;
        logic [15:0] phase_ms;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_cmdq_status;

endpackage
`default_nettype wire

[sv/qlbs_front.sv]
// Front end: accepts input requests, decodes them into operations.
`default_nettype none
module qlbs_front import qlbs_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire t_in_item     i_data,
    output logic              o_stall,
    input  wire t_cmdq_status i_q_status,
    output logic              o_push,
    output t_op               o_op
);

    logic r_valid;
    logic n_valid;
    t_op  r_op;
    t_op  n_op;
    logic w_load;

    assign o_stall = r_valid && i_q_status.full;
    assign w_load  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_status.full;
    assign o_op    = r_op;

    always_comb begin
        n_valid           = w_load || (r_valid && !o_push);
        n_op              = r_op;
        if (w_load) begin
            n_op.blink_count = i_data.blink_count;
            n_op.phase_ms    = i_data.phase_ms;
            n_op.force_req   = i_data.force_req;
            n_op.level       = 1'b0;
            unique case (t_cmd'(i_data.command))
                CMD_TICK:  n_op.kind = OP_TICK;
                CMD_BLINK: n_op.kind = OP_BLINK;
                CMD_ON: begin
                    n_op.kind  = OP_DIRECT;
                    n_op.level = 1'b1;
                end
                default:   n_op.kind = OP_DIRECT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_op <= n_op;
    end

endmodule
`default_nettype wire

[sv/qlbs_cmdq.sv]
// Short operation queue between front end and sequencer back end.
`default_nettype none
module qlbs_cmdq import qlbs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_op     i_op,
    input  wire logic    i_pop,
    output t_op          o_op,
    output t_cmdq_status o_status
);

    t_op                   r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_cnt;
    logic                  w_push;
    logic                  w_pop;

    assign o_status.full  = (r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_op           = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule
`default_nettype wire

[sv/qlbs_back.sv]
// Back end: blink sequencer, request FIFO and result register.
`default_nettype none
module qlbs_back import qlbs_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_led_enable,
    input  wire t_op          i_op,
    input  wire t_cmdq_status i_q_status,
    output logic              o_pop,
    output logic              o_valid,
    output t_out_item         o_data,
    input  wire logic         i_stall
);

    logic                 r_led,     n_led;
    logic                 r_running, n_running;
    logic                 r_lit,     n_lit;
    logic                 r_gap,     n_gap;
    logic [7:0]           r_done,    n_done;
    logic [7:0]           r_wanted,  n_wanted;
    logic [ELAPSED_W-1:0] r_plen,    n_plen;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [PTR_W-1:0]     r_rd_ptr,  n_rd_ptr;
    logic [PTR_W-1:0]     r_wr_ptr,  n_wr_ptr;
    logic [FILL_W-1:0]    r_fill,    n_fill;
    logic [23:0]          r_fifo [QUEUE_DEPTH];
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 w_go;
    logic                 w_wr;
    logic                 w_acc;
    logic [ELAPSED_W-1:0] w_el;
    logic [23:0]          w_head;

    assign w_go    = !i_q_status.empty && (!r_out_valid || !i_stall);
    assign o_pop   = w_go;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign w_head  = r_fifo[r_rd_ptr];
    assign w_el    = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        n_led     = r_led;
        n_running = r_running;
        n_lit     = r_lit;
        n_gap     = r_gap;
        n_done    = r_done;
        n_wanted  = r_wanted;
        n_plen    = r_plen;
        n_elapsed = r_elapsed;
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_fill    = r_fill;
        w_wr      = 1'b0;
        w_acc     = 1'b1;
        unique case (i_op.kind)
            OP_TICK: begin
                if (r_running) begin
                    n_elapsed = w_el;
                    if (w_el > r_plen) begin
                        if (r_gap) begin
                            n_gap     = 1'b0;
                            n_running = 1'b0;
                        end else if (r_lit) begin
                            n_lit     = 1'b0;
                            n_elapsed = '0;
                            if (i_led_enable) begin
                                n_led = 1'b0;
                            end
                            if ({1'b0, r_done} + 9'd1 >= {1'b0, r_wanted}) begin
                                n_plen = r_plen << GAP_SHIFT;
                                n_gap  = 1'b1;
                            end
                        end else begin
                            n_done    = r_done + 8'd1;
                            n_lit     = 1'b1;
                            n_elapsed = '0;
                            if (i_led_enable) begin
                                n_led = 1'b1;
                            end
                        end
                    end
                end
                if (!n_running && r_fill != '0) begin
                    n_rd_ptr  = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
                    n_fill    = r_fill - 1'b1;
                    n_wanted  = w_head[7:0];
                    n_plen    = {{(ELAPSED_W-16){1'b0}}, w_head[23:8]};
                    n_elapsed = '0;
                    n_lit     = 1'b1;
                    n_running = 1'b1;
                    n_done    = '0;
                    n_gap     = 1'b0;
                    if (i_led_enable) begin
                        n_led = 1'b1;
                    end
                end
            end
            OP_BLINK: begin
                if (r_fill != FILL_W'(QUEUE_DEPTH)) begin
                    w_wr     = 1'b1;
                    n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                    n_fill   = r_fill + 1'b1;
                end else begin
                    w_acc = 1'b0;
                end
            end
            default: begin
                if ((i_op.force_req || !r_running) && i_led_enable) begin
                    n_led = i_op.level;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led       <= 1'b0;
            r_running   <= 1'b0;
            r_lit       <= 1'b1;
            r_gap       <= 1'b0;
            r_done      <= '0;
            r_wanted    <= '0;
            r_plen      <= '0;
            r_elapsed   <= '0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_led     <= n_led;
                r_running <= n_running;
                r_lit     <= n_lit;
                r_gap     <= n_gap;
                r_done    <= n_done;
                r_wanted  <= n_wanted;
                r_plen    <= n_plen;
                r_elapsed <= n_elapsed;
                r_rd_ptr  <= n_rd_ptr;
                r_wr_ptr  <= n_wr_ptr;
                r_fill    <= n_fill;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_go) begin
            r_out.led_lit  <= n_led;
            r_out.accepted <= w_acc;
            r_out.busy_res <= n_running;
        end
        if (w_go && w_wr) begin
            r_fifo[r_wr_ptr] <= {i_op.phase_ms, i_op.blink_count};
        end
    end

endmodule
`default_nettype wire

[sv/queued_led_blink_sequencer_core.sv]
// Top level: queued LED blink sequencer with APB enable register.
// Sustains one request per clock unless a stall holds it back. A request
// passes the front decode register, a four-entry operation queue and the
// sequencer, whose output register holds the result. Each request yields one
// result (LED level, accepted flag, busy flag). Blink requests wait in an
// eight-entry FIFO that the sequencer drains on 1 ms tick requests.
`default_nettype none
module queued_led_blink_sequencer_core import qlbs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire t_in_item              i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output t_out_item                  o_data,
    input  wire logic                  i_stall,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic         r_led_enable;
    logic         w_push;
    logic         w_pop;
    t_op          w_front_op;
    t_op          w_q_op;
    t_cmdq_status w_q_status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LED_ENABLE) ? {31'd0, r_led_enable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_enable <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_LED_ENABLE) begin
            r_led_enable <= pwdata[0];
        end
    end

    qlbs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_op       (w_front_op)
    );

    qlbs_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_op     (w_front_op),
        .i_pop    (w_pop),
        .o_op     (w_q_op),
        .o_status (w_q_status)
    );

    qlbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_led_enable (r_led_enable),
        .i_op         (w_q_op),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_data       (o_data),
        .i_stall      (i_stall)
    );

endmodule
`default_nettype wire

[test/queued_led_blink_sequencer_core_test.sv]
// Self-checking testbench for the queued LED blink sequencer core.
`timescale 1ns / 100ps
module queued_led_blink_sequencer_core_test;
    import qlbs_pkg::*;

    typedef struct packed {
        logic     hold;
        t_in_item item;
    } t_pending;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    t_in_item              i_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out_item             o_data;
    logic                  i_stall = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    queued_led_blink_sequencer_core uut (.*);

    always #5 i_clk = ~i_clk;

    // sequencer state as predicted
    logic              m_led_en, m_led, m_running, m_lit, m_gap;
    logic [7:0]        m_done, m_wanted;
    logic [17:0]       m_phase, m_elapsed;
    logic [23:0]       m_fifo [QUEUE_DEPTH];
    logic [PTR_W-1:0]  m_rd, m_wr;
    logic [FILL_W-1:0] m_fill;

    t_pending  item_q [$];
    t_out_item led_expect_q [$];
    logic      req_taken = 1'b0;
    int        n_sent = 0, n_taken = 0, n_results = 0, n_queued = 0, n_errors = 0;
    int        n_ticks = 0, n_blink_ok = 0, n_blink_full = 0, n_direct = 0;
    int        n_seq_start = 0, n_seq_done = 0;
    int        gap_left = 0, stall_left = 0, calm_left = 0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left != 0 || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_count();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 9);
    endfunction

    function automatic logic [15:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(9, 30);
    endfunction

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic led_drive(input logic lvl);
        if (m_led_en) m_led = lvl;
    endtask

    task automatic blink_seq_step(input t_in_item req, output t_out_item res);
        logic ok;
        ok = 1'b1;
        case (req.command)
            CMD_TICK: begin
                n_ticks++;
                if (m_running) begin
                    if (m_elapsed != ELAPSED_MAX) m_elapsed = m_elapsed + 1'b1;
                    if (m_elapsed > m_phase) begin
                        if (m_gap) begin
                            m_gap = 1'b0;
                            m_running = 1'b0;
                            n_seq_done++;
                        end else if (m_lit) begin
                            m_lit = 1'b0;
                            led_drive(1'b0);
                            m_elapsed = '0;
                            if ({1'b0, m_done} + 9'd1 >= {1'b0, m_wanted}) begin
                                m_phase = m_phase << GAP_SHIFT;
                                m_gap = 1'b1;
                            end
                        end else begin
                            m_done = m_done + 1'b1;
                            m_lit = 1'b1;
                            led_drive(1'b1);
                            m_elapsed = '0;
                        end
                    end
                end
                if (!m_running && m_fill != 0) begin
                    m_wanted = m_fifo[m_rd][7:0];
                    m_phase = {2'b00, m_fifo[m_rd][23:8]};
                    m_rd = (m_rd == QUEUE_DEPTH - 1) ? '0 : m_rd + 1'b1;
                    m_fill = m_fill - 1'b1;
                    m_elapsed = '0;
                    led_drive(1'b1);
                    m_lit = 1'b1;
                    m_running = 1'b1;
                    m_done = '0;
                    m_gap = 1'b0;
                    n_seq_start++;
                end
            end
            CMD_BLINK: begin
                if (m_fill < QUEUE_DEPTH) begin
                    m_fifo[m_wr] = {req.phase_ms, req.blink_count};
                    m_wr = (m_wr == QUEUE_DEPTH - 1) ? '0 : m_wr + 1'b1;
                    m_fill = m_fill + 1'b1;
                    n_blink_ok++;
                end else begin
                    ok = 1'b0;
                    n_blink_full++;
                end
            end
            default: begin
                n_direct++;
                if (req.force_req || !m_running) led_drive(req.command == CMD_ON);
            end
        endcase
        res.led_lit  = m_led;
        res.accepted = ok;
        res.busy_res = m_running;
    endtask

    // result checker and predictor
    always @(posedge i_clk) begin
        t_out_item want;
        req_taken <= i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (led_expect_q.size() == 0) begin
                    flag_error($sformatf("unexpected result led %b acc %b busy %b",
                                         o_data.led_lit, o_data.accepted, o_data.busy_res));
                end else begin
                    want = led_expect_q.pop_front();
                    if (o_data.led_lit !== want.led_lit || o_data.accepted !== want.accepted ||
                        o_data.busy_res !== want.busy_res)
                        flag_error($sformatf(
                            "result %0d: expected led %b acc %b busy %b, got led %b acc %b busy %b",
                            n_results, want.led_lit, want.accepted, want.busy_res,
                            o_data.led_lit, o_data.accepted, o_data.busy_res));
                end
            end
            if (i_valid && !o_stall) begin
                blink_seq_step(i_data, want);
                led_expect_q.push_back(want);
                n_taken++;
            end
        end
    end

    // request driver and result-side stall
    always @(negedge i_clk) begin
        t_pending nxt;
        if (calm_left != 0) calm_left--;
        else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 150);

        if (stall_left != 0) stall_left--;
        else stall_left = idle_len();
        i_stall <= (stall_left != 0);

        if (!i_valid || req_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (item_q.size() != 0 &&
                         !(item_q[0].hold && (led_expect_q.size() != 0 || n_taken != n_sent))) begin
                nxt = item_q.pop_front();
                i_data <= nxt.item;
                i_valid <= 1'b1;
                n_sent++;
                gap_left = idle_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic queue_req(input t_cmd cmd, input logic [7:0] cnt, input logic [15:0] dly,
                             input logic frc, input bit hold);
        t_pending p;
        p.hold = hold;
        p.item.command = cmd;
        p.item.blink_count = cnt;
        p.item.phase_ms = dly;
        p.item.force_req = frc;
        item_q.push_back(p);
        n_queued++;
    endtask

    task automatic settle();
        while (item_q.size() != 0 || n_taken != n_sent || led_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_set_led_en(input logic val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_LED_ENABLE;
        pwdata <= {31'b0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        m_led_en = val;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== val)
            flag_error($sformatf("led_enable reads %b, wrote %b", prdata[0], val));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        int goal, r, k, j;
        bit hold;
        goal = n_queued + n;
        queue_req(CMD_TICK, $urandom, $urandom, $urandom, 1'b1);
        while (n_queued < goal) begin
            r = $urandom_range(0, 99);
            hold = ($urandom_range(0, 19) == 0);
            if (r < 70) begin
                k = $urandom_range(1, 2);
                for (j = 0; j < k; j++)
                    queue_req(CMD_BLINK, pick_count(), pick_delay(), $urandom, hold && j == 0);
                k = $urandom_range(6, 40);
                for (j = 0; j < k; j++) begin
                    if ($urandom_range(0, 99) < 12)
                        queue_req(($urandom_range(0, 1) != 0) ? CMD_ON : CMD_OFF,
                                  $urandom, $urandom, $urandom, 1'b0);
                    else
                        queue_req(CMD_TICK, $urandom, $urandom, $urandom, 1'b0);
                end
            end else if (r < 85) begin
                k = $urandom_range(1, 5);
                for (j = 0; j < k; j++)
                    queue_req(t_cmd'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 3)),
                              $urandom, $urandom, $urandom, hold && j == 0);
            end else if (r < 90) begin
                // eight small requests fill the queue, the wide ones behind are refused
                for (j = 0; j < QUEUE_DEPTH; j++)
                    queue_req(CMD_BLINK, pick_count(), pick_delay(), $urandom, hold && j == 0);
                k = $urandom_range(1, 3);
                for (j = 0; j < k; j++)
                    queue_req(CMD_BLINK, $urandom, $urandom, $urandom, 1'b0);
            end else begin
                k = $urandom_range(0, 3);
                if (k == CMD_BLINK)
                    queue_req(CMD_BLINK, pick_count(), pick_delay(), $urandom, hold);
                else
                    queue_req(t_cmd'(k), $urandom, $urandom, $urandom, hold);
            end
        end
    endtask

    initial begin
        m_led_en = 1'b1;
        m_led = 1'b0;
        m_running = 1'b0;
        m_lit = 1'b1;
        m_gap = 1'b0;
        m_done = '0;
        m_wanted = '0;
        m_phase = '0;
        m_elapsed = '0;
        m_rd = '0;
        m_wr = '0;
        m_fill = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_set_led_en(1'b1);
        queue_req(CMD_ON, 0, 0, 1'b0, 1'b0);
        queue_req(CMD_OFF, 255, 65535, 1'b0, 1'b0);
        queue_req(CMD_TICK, 0, 0, 1'b0, 1'b0);
        queue_req(CMD_BLINK, 0, 0, 1'b0, 1'b0);      // zero count runs one flash
        queue_req(CMD_TICK, 255, 65535, 1'b1, 1'b0);
        queue_req(CMD_OFF, 0, 0, 1'b0, 1'b0);        // ignored while running
        queue_req(CMD_OFF, 0, 0, 1'b1, 1'b0);        // forced
        queue_req(CMD_ON, 0, 0, 1'b1, 1'b0);
        queue_req(CMD_TICK, 0, 0, 1'b0, 1'b0);
        queue_req(CMD_TICK, 0, 0, 1'b0, 1'b0);
        for (int j = 0; j < QUEUE_DEPTH; j++)
            queue_req(CMD_BLINK, j % 3, j % 2, 1'b0, 1'b0);
        queue_req(CMD_BLINK, 255, 65535, 1'b1, 1'b0); // queue full
        queue_req(CMD_TICK, 0, 0, 1'b0, 1'b0);
        queue_req(CMD_ON, 0, 0, 1'b0, 1'b0);
        queue_req(CMD_OFF, 0, 0, 1'b1, 1'b0);
        random_phase(290);
        settle();

        apb_set_led_en(1'b0);
        random_phase(310);
        settle();

        apb_set_led_en(1'b1);
        random_phase(310);
        settle();

        $display("%0d requests checked: %0d ticks, %0d blinks queued, %0d refused full, %0d on/off",
                 n_taken, n_ticks, n_blink_ok, n_blink_full, n_direct);
        $display("%0d blink sequences started, %0d completed, %0d mismatches",
                 n_seq_start, n_seq_done, n_errors);
        if (n_errors == 0) begin
            $display("** queued_led_blink_sequencer_core: PASSED **");
        end else begin
            $display("** queued_led_blink_sequencer_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout: %0d requests sent, %0d results pending", n_sent, led_expect_q.size());
        $display("** queued_led_blink_sequencer_core: FAILED **");
        $finish;
    end

endmodule

[files.f]
sv/qlbs_pkg.sv
sv/qlbs_front.sv
sv/qlbs_cmdq.sv
sv/qlbs_back.sv
sv/queued_led_blink_sequencer_core.sv
test/queued_led_blink_sequencer_core_test.sv
